// ===== hdl/ray_box_slab_intersect_unit_macros.svh =====
// Assertion macros shared by the ray box slab intersect unit.
`ifndef RAY_BOX_SLAB_INTERSECT_UNIT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RBSI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsi assertion failed");

// Implication with a fixed delay in cycles.
`define RBSI_ASSERT_LATER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("rbsi assertion failed");

`endif

// ===== hdl/rbsi_pkg.sv =====
// Package with the constants and types of the ray box slab intersect unit.
package rbsi_pkg;

   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
   localparam int unsigned RESP_LAT  = DIV_LAT + 5;

   localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;

   localparam logic [15:0] AXIS_EPS_RESET = 16'd1;
   localparam logic [15:0] CLIP_EPS_RESET = 16'd1;

   typedef enum logic [0:0] {
      REG_AXIS_EPS = 1'b0,
      REG_CLIP_EPS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] parallel;
      logic       contained;
   } side_type;

endpackage

// ===== hdl/rbsi_div.sv =====
// Pipelined signed Q16.16 slab divider with saturation, one bit per stage.
module rbsi_div (
   input  logic               clock,
   input  logic [31:0]        n_mag,
   input  logic [31:0]        d_mag,
   input  logic               neg,
   output logic signed [31:0] quot
);
   import rbsi_pkg::*;

   logic [31:0] rem_ff [0:DIV_STEPS];
   logic [31:0] q_ff   [0:DIV_STEPS];
   logic [15:0] low_ff [0:DIV_STEPS];
   logic [31:0] dv_ff  [0:DIV_STEPS];
   logic        neg_ff [0:DIV_STEPS];
   logic        ovf_ff [0:DIV_STEPS];
   logic signed [31:0] quot_ff;
   logic signed [31:0] quot_in;
   logic        ovf_in;

   assign ovf_in = (d_mag[31:16] == 16'd0) && (n_mag >= {d_mag[15:0], 16'd0});

   always_ff @(posedge clock) begin
      rem_ff[0] <= {16'd0, n_mag[31:16]};
      q_ff[0]   <= '0;
      low_ff[0] <= n_mag[15:0];
      dv_ff[0]  <= d_mag;
      neg_ff[0] <= neg;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic        bit_in;
      logic [32:0] trial;
      logic        take;
      if (k < 16) begin : g_low
         assign bit_in = low_ff[k][15-k];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end
      assign trial = {rem_ff[k], bit_in};
      assign take  = trial >= {1'b0, dv_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= take ? 32'(trial - {1'b0, dv_ff[k]}) : trial[31:0];
         q_ff[k+1]   <= {q_ff[k][30:0], take};
         low_ff[k+1] <= low_ff[k];
         dv_ff[k+1]  <= dv_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   always_comb begin
      if (neg_ff[DIV_STEPS]) begin
         if (ovf_ff[DIV_STEPS] || (q_ff[DIV_STEPS] > 32'h8000_0000)) begin
            quot_in = QMIN;
         end else begin
            quot_in = -$signed(q_ff[DIV_STEPS]);
         end
      end else begin
         if (ovf_ff[DIV_STEPS] || q_ff[DIV_STEPS][31]) begin
            quot_in = QMAX;
         end else begin
            quot_in = $signed(q_ff[DIV_STEPS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== hdl/ray_box_slab_intersect_unit.sv =====
// Top level of the ray box slab intersect unit: ports, registers and slab pipeline.
// One ray test is accepted in every cycle (busy stays low) and its result appears
// on rsp_valid after the input, numerator, divider, order, combine and result
// registers; six parallel bit-per-stage dividers work out the slab distances.
// Results cannot be held off, so the pipeline never stalls.
module ray_box_slab_intersect_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [30:0]        req_half_x,
   input  logic [30:0]        req_half_y,
   input  logic [30:0]        req_half_z,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [30:0]        rsp_t_enter,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import rbsi_pkg::*;

   `include "ray_box_slab_intersect_unit_macros.svh"

   logic [15:0] axis_eps_ff;
   logic [15:0] clip_eps_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_eps_ff <= AXIS_EPS_RESET;
         clip_eps_ff <= CLIP_EPS_RESET;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_AXIS_EPS: axis_eps_ff <= csr_pwdata[15:0];
            REG_CLIP_EPS: clip_eps_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_AXIS_EPS: csr_prdata = {16'd0, axis_eps_ff};
         REG_CLIP_EPS: csr_prdata = {16'd0, clip_eps_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign busy = 1'b0;

   // Input register stage.
   logic               a_valid_ff;
   logic signed [31:0] a_o_ff [0:2];
   logic signed [31:0] a_d_ff [0:2];
   logic [30:0]        a_h_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_o_ff[0] <= req_origin_x;
      a_o_ff[1] <= req_origin_y;
      a_o_ff[2] <= req_origin_z;
      a_d_ff[0] <= req_dir_x;
      a_d_ff[1] <= req_dir_y;
      a_d_ff[2] <= req_dir_z;
      a_h_ff[0] <= req_half_x;
      a_h_ff[1] <= req_half_y;
      a_h_ff[2] <= req_half_z;
   end

   // Numerator stage.
   logic [31:0] b_nmag_ff [0:5];
   logic        b_neg_ff  [0:5];
   logic [31:0] b_dmag_ff [0:2];
   side_type    side_b_ff;
   side_type    side_b_in;
   logic [2:0]  par_in;
   logic [2:0]  inside_in;

   for (genvar a = 0; a < 3; a++) begin : g_num
      logic signed [33:0] o34;
      logic signed [33:0] h34;
      logic signed [33:0] ce34;
      logic signed [33:0] na;
      logic signed [33:0] nb;
      logic signed [32:0] d33;
      logic [31:0]        dmag;
      assign o34  = 34'(a_o_ff[a]);
      assign h34  = $signed({3'b000, a_h_ff[a]});
      assign ce34 = $signed({18'd0, clip_eps_ff});
      assign na   = -h34 - o34;
      assign nb   = h34 - o34;
      assign d33  = 33'(a_d_ff[a]);
      assign dmag = d33[32] ? 32'(-d33) : d33[31:0];
      assign par_in[a]    = dmag <= {16'd0, axis_eps_ff};
      assign inside_in[a] = !par_in[a] || ((o34 >= -h34 - ce34) && (o34 <= h34 + ce34));
      always_ff @(posedge clock) begin
         b_nmag_ff[2*a]   <= na[33] ? 32'(-na) : na[31:0];
         b_nmag_ff[2*a+1] <= nb[33] ? 32'(-nb) : nb[31:0];
         b_neg_ff[2*a]    <= na[33] ^ a_d_ff[a][31];
         b_neg_ff[2*a+1]  <= nb[33] ^ a_d_ff[a][31];
         b_dmag_ff[a]     <= dmag;
      end
   end

   always_comb begin
      side_b_in.valid     = a_valid_ff;
      side_b_in.parallel  = par_in;
      side_b_in.contained = &inside_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff <= '0;
      end else begin
         side_b_ff <= side_b_in;
      end
   end

   // Dividers, with the side information delayed alongside.
   logic signed [31:0] t_div [0:5];
   side_type           side_ff [0:DIV_LAT-1];

   for (genvar p = 0; p < 6; p++) begin : g_div
      rbsi_div u_div (
         .clock (clock),
         .n_mag (b_nmag_ff[p]),
         .d_mag (b_dmag_ff[p/2]),
         .neg   (b_neg_ff[p]),
         .quot  (t_div[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= side_b_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Order the slab distances on each axis.
   logic signed [31:0] e_lo_ff [0:2];
   logic signed [31:0] e_hi_ff [0:2];
   side_type           side_e_ff;

   for (genvar a = 0; a < 3; a++) begin : g_order
      logic swap;
      assign swap = t_div[2*a] > t_div[2*a+1];
      always_ff @(posedge clock) begin
         if (side_ff[DIV_LAT-1].parallel[a]) begin
            e_lo_ff[a] <= '0;
            e_hi_ff[a] <= QMAX;
         end else begin
            e_lo_ff[a] <= swap ? t_div[2*a+1] : t_div[2*a];
            e_hi_ff[a] <= swap ? t_div[2*a] : t_div[2*a+1];
         end
      end
   end

   // Combine the axes into the entry and exit distances.
   logic signed [31:0] f_enter_ff;
   logic signed [31:0] f_exit_ff;
   logic signed [31:0] enter_in;
   logic signed [31:0] exit_in;
   side_type           side_f_ff;

   always_comb begin
      enter_in = '0;
      exit_in  = QMAX;
      for (int a = 0; a < 3; a++) begin
         if (e_lo_ff[a] > enter_in) begin
            enter_in = e_lo_ff[a];
         end
         if (e_hi_ff[a] < exit_in) begin
            exit_in = e_hi_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_e_ff <= '0;
         side_f_ff <= '0;
      end else begin
         side_e_ff <= side_ff[DIV_LAT-1];
         side_f_ff <= side_e_ff;
      end
      f_enter_ff <= enter_in;
      f_exit_ff  <= exit_in;
   end

   // Final overlap test and result register.
   logic signed [33:0] ce_s;
   logic signed [33:0] enter_s;
   logic signed [33:0] exit_s;
   logic               ok;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [30:0]        rsp_t_ff;

   assign ce_s    = $signed({18'd0, clip_eps_ff});
   assign enter_s = 34'(f_enter_ff);
   assign exit_s  = 34'(f_exit_ff);
   assign ok      = side_f_ff.contained && (enter_s <= exit_s + ce_s) && (exit_s >= -ce_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         rsp_t_ff     <= '0;
      end else begin
         rsp_valid_ff <= side_f_ff.valid;
         rsp_hit_ff   <= side_f_ff.valid && ok;
         rsp_t_ff     <= (side_f_ff.valid && ok) ? f_enter_ff[30:0] : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_t_enter = rsp_t_ff;

   `RBSI_ASSERT_LATER(a_transfer_answered, clock, reset, start && !busy, RESP_LAT, rsp_valid)
   `RBSI_ASSERT_NOW(a_result_had_transfer, clock, reset, rsp_valid, $past(start && !busy, RESP_LAT))
   `RBSI_ASSERT_NOW(a_miss_zero_distance, clock, reset, !rsp_hit, rsp_t_enter == 31'd0)

endmodule

// ===== sim/ray_box_slab_intersect_unit_checker.sv =====
// Checker that predicts the ray box slab test results and compares them with the block.
module ray_box_slab_intersect_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [30:0]        req_half_x,
   input  logic [30:0]        req_half_y,
   input  logic [30:0]        req_half_z,
   input  logic               rsp_valid,
   input  logic               rsp_hit,
   input  logic [30:0]        rsp_t_enter,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 failures,
   output int                 pending
);
   import rbsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        hit;
      logic [30:0] t_enter;
   } slab_outcome_type;

   logic [15:0] axis_eps;
   logic [15:0] clip_eps;
   slab_outcome_type outcome_queue[$];

   function automatic longint clamp_q(longint v);
      if (v > longint'(QMAX)) return longint'(QMAX);
      if (v < longint'(QMIN)) return longint'(QMIN);
      return v;
   endfunction

   function automatic slab_outcome_type slab_test(
      longint o[3], longint d[3], longint h[3], logic [15:0] ae, logic [15:0] ce16);
      slab_outcome_type r;
      longint enter_t, exit_t, ce, ad, ta, tb, tmp;
      bit ok;
      ce = longint'(ce16);
      enter_t = 0;
      exit_t = longint'(QMAX);
      ok = 1;
      for (int a = 0; a < 3; a++) begin
         if (ok) begin
            ad = d[a] < 0 ? -d[a] : d[a];
            if (ad <= longint'(ae) || d[a] == 0) begin
               ok = (o[a] >= -h[a] - ce) && (o[a] <= h[a] + ce);
            end else begin
               ta = clamp_q(((-h[a] - o[a]) * 65536) / d[a]);
               tb = clamp_q(((h[a] - o[a]) * 65536) / d[a]);
               if (ta > tb) begin
                  tmp = ta;
                  ta = tb;
                  tb = tmp;
               end
               if (ta > enter_t) enter_t = ta;
               if (tb < exit_t) exit_t = tb;
               ok = enter_t <= exit_t + ce;
            end
         end
      end
      if (ok && exit_t < -ce) ok = 0;
      r.hit = ok;
      r.t_enter = ok ? ((enter_t < 0) ? 31'd0 : enter_t[30:0]) : 31'd0;
      return r;
   endfunction

   assign pending = outcome_queue.size();

   always @(posedge clock) begin
      longint o[3], d[3], h[3];
      slab_outcome_type want;
      if (reset) begin
         axis_eps <= AXIS_EPS_RESET;
         clip_eps <= CLIP_EPS_RESET;
         outcome_queue.delete();
         failures <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_CLIP_EPS) clip_eps <= csr_pwdata[15:0];
            else axis_eps <= csr_pwdata[15:0];
         end
         if (start && !busy) begin
            o = '{req_origin_x, req_origin_y, req_origin_z};
            d = '{req_dir_x, req_dir_y, req_dir_z};
            h = '{longint'(req_half_x), longint'(req_half_y), longint'(req_half_z)};
            outcome_queue.push_back(slab_test(o, d, h, axis_eps, clip_eps));
         end
         if (rsp_valid) begin
            if (outcome_queue.size() == 0) begin
               $error("result transfer with no expectation waiting");
               failures <= failures + 1;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_hit !== want.hit || rsp_t_enter !== want.t_enter) begin
                  if (rsp_hit !== want.hit)
                     $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  if (rsp_t_enter !== want.t_enter)
                     $error("t_enter: expected %h, got %h", want.t_enter, rsp_t_enter);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/ray_box_slab_intersect_unit_tb.sv =====
// Top of the ray box slab intersect unit testbench: clock, reset, stimulus and verdict.
module ray_box_slab_intersect_unit_tb;
   import rbsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   logic clock, reset, start, busy;
   logic signed [31:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic [30:0] req_half_x, req_half_y, req_half_z;
   logic rsp_valid, rsp_hit;
   logic [30:0] rsp_t_enter;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int failures, pending, cycles;

   ray_box_slab_intersect_unit dut (.*);
   ray_box_slab_intersect_unit_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = 3'(idx) << 2;
      csr_pwdata = {16'h0, value};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
      bit taken;
      @(negedge clock);
      start = 1;
      req_origin_x = ox; req_origin_y = oy; req_origin_z = oz;
      req_dir_x = dx; req_dir_y = dy; req_dir_z = dz;
      req_half_x = hx; req_half_y = hy; req_half_z = hz;
      do begin
         #1 taken = !busy;
         @(posedge clock);
         if (!taken) @(negedge clock);
      end while (!taken);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start = 0;
      end
   endtask

   task automatic drain;
      idle_cycles(1);
      while (pending != 0) @(negedge clock);
      idle_cycles(RESP_LAT + 4);
   endtask

   function automatic logic [31:0] pick_dir(logic [15:0] ae);
      int sel;
      logic [31:0] m;
      sel = $urandom_range(0, 9);
      case (sel)
         0: m = 0;
         1: m = ae;
         2: m = ae + 1;
         3: m = $urandom;
         default: m = $urandom_range(1, 1 << 18);
      endcase
      return ($urandom_range(0, 1) && sel != 3) ? -m : m;
   endfunction

   function automatic logic [31:0] pick_origin(logic [30:0] h);
      if ($urandom_range(0, 19) == 0) return $urandom;
      return $signed($urandom_range(0, 6 * h + 2)) - $signed(3 * h + 1);
   endfunction

   function automatic logic [30:0] pick_half();
      if ($urandom_range(0, 19) == 0) return 31'($urandom);
      return 31'($urandom_range(0, 12 << 16));
   endfunction

   task automatic random_rays(int n, logic [15:0] ae);
      logic [30:0] hx, hy, hz;
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && n > 0) begin
            hx = pick_half(); hy = pick_half(); hz = pick_half();
            send_ray(pick_origin(hx), pick_origin(hy), pick_origin(hz),
                     pick_dir(ae), pick_dir(ae), pick_dir(ae), hx, hy, hz);
            burst--;
            n--;
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [15:0] ae_list[4], ce_list[4];
      cycles = 0;
      reset = 1;
      start = 0;
      {req_origin_x, req_origin_y, req_origin_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      {req_half_x, req_half_y, req_half_z} = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_ray(0, 0, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000);
      send_ray(32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(0, 32'h0001_0001, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(0, 32'h0001_0002, 0, 32'h0001_0000, 1, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2, 3,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_ray(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
      send_ray(32'hFF00_0000, 0, 0, 2, 0, 0, 31'h10, 31'h10, 31'h10);
      send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
               32'hFFFF_0000, 32'hFFFF_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000);
      send_ray(32'h0003_0000, 32'h0003_0000, 0, 32'hFFFF_0000, 32'h0001_0000, 0,
               31'h1_0000, 31'h1_0000, 31'h1_0000);
      send_ray(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(32'h0001_0001, 0, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 31'h1_0000,
               31'h1_0000);
      send_ray(32'hFFFF_FFFE, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'h0000_0002, 31'h1, 31'h7FFF_FFFF, 31'h2);
      drain();

      ae_list = '{16'd0, 16'hFFFF, 16'h0100, 16'($urandom)};
      ce_list = '{16'hFFFF, 16'd0, 16'h0040, 16'($urandom)};
      random_rays(250, AXIS_EPS_RESET);
      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(REG_AXIS_EPS, ae_list[p]);
         write_reg(REG_CLIP_EPS, ce_list[p]);
         send_ray(0, 32'h0001_0000 + ce_list[p], 0, ae_list[p], 0, 0,
                  31'h1_0000, 31'h1_0000, 31'h1_0000);
         random_rays(145, ae_list[p]);
      end
      drain();

      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rbsi_pkg.sv
hdl/rbsi_div.sv
hdl/ray_box_slab_intersect_unit.sv
sim/ray_box_slab_intersect_unit_checker.sv
sim/ray_box_slab_intersect_unit_tb.sv
